@@ src/sbcd_pkg.sv @@
// Shared constants and types for the sign-magnitude BCD adder/subtractor.
// No dependencies; used by every module of the block.
package sbcd_pkg;

	// operand size in decimal digits and the number of digit lanes working in parallel
	localparam int DIGITS = 16;
	localparam int LANES  = 4;

	// walk over the magnitude: digits are handled LANES at a time
	localparam int STEPS      = (DIGITS + LANES - 1) / LANES;
	localparam int STEP_W     = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int LAST_STEP  = (DIGITS - 1) / LANES;
	localparam int LAST_LANE  = (DIGITS - 1) % LANES;
	localparam int PAD_W      = 4 * STEPS * LANES;
	localparam int DIG_W      = 4 * DIGITS;
	localparam int LANE_DW    = 4 * LANES;

	// stream widths
	localparam int FIELD_W = 64;
	localparam int CNT_W   = 5;
	localparam int IN_W    = 136;
	localparam int OUT_W   = 72;

	typedef logic [PAD_W-1:0] pad_t;
	typedef logic [3:0]       nibble_t;

	// one finished result
	typedef struct packed {
		logic [CNT_W-1:0]   digit_count;
		logic               carry_digit;
		logic [FIELD_W-1:0] sum_digits;
		logic               sum_negative;
	} result_t;

endpackage

@@ src/sbcd_digit_cell.sv @@
// One decimal digit cell: add with carry or subtract with borrow.
// Depends on sbcd_pkg.
module sbcd_digit_cell
	import sbcd_pkg::*;
(
	input  logic    sub,
	input  nibble_t x,
	input  nibble_t y,
	input  logic    cin,
	output nibble_t d,
	output logic    cout
);

	logic [4:0] sum;
	logic [4:0] ysub;
	logic [4:0] wrap;

	// add path: s = x + y + c, fold at ten; subtract path: x - (y + b), wrap by ten
	always_comb begin
		sum  = 5'({1'b0, x}) + 5'({1'b0, y}) + 5'(cin);
		ysub = 5'({1'b0, y}) + 5'(cin);
		wrap = 5'({1'b0, x}) + 5'd10 - ysub;
		if (sub) begin
			if ({1'b0, x} < ysub) begin
				d    = wrap[3:0];
				cout = 1'b1;
			end else begin
				d    = 4'(5'({1'b0, x}) - ysub);
				cout = 1'b0;
			end
		end else begin
			if (sum >= 5'd10) begin
				d    = 4'(sum - 5'd10);
				cout = 1'b1;
			end else begin
				d    = sum[3:0];
				cout = 1'b0;
			end
		end
	end

endmodule

@@ src/sbcd_merge.sv @@
// Merge stage: combines the lane results into sign, digits, carry and digit count.
// Depends on sbcd_pkg.
module sbcd_merge
	import sbcd_pkg::*;
(
	input  logic [DIG_W-1:0] digits,
	input  logic             carry,
	input  logic             negative,
	output result_t          result
);

	logic [CNT_W-1:0] top;
	logic             zero;

	// highest non-zero digit sets the count
	always_comb begin
		top = CNT_W'(1);
		for (int i = 0; i < DIGITS; i++) begin
			if (digits[4*i +: 4] != 4'd0) begin
				top = CNT_W'(i + 1);
			end
		end
	end

	// zero is always positive; a carry makes the result DIGITS+1 long
	always_comb begin
		zero                = (digits == '0) && !carry;
		result.sum_negative = negative && !zero;
		result.sum_digits   = FIELD_W'(digits);
		result.carry_digit  = carry;
		result.digit_count  = carry ? CNT_W'(DIGITS + 1) : top;
	end

endmodule

@@ src/signed_bcd_adder.sv @@
// Top level of the sign-magnitude BCD adder/subtractor.
// Depends on sbcd_pkg, sbcd_digit_cell and sbcd_merge.
//
// Channel | Dir | Bits of tdata (lowest first)
// s_*     | in  | a_negative[0], a_digits[64:1], b_negative[65], b_digits[129:66], zero pad
// m_*     | out | sum_negative[0], sum_digits[64:1], carry_digit[65], digit_count[70:66], pad
//
// Each item is handled in order: the beat is taken and the magnitudes compared, the digits
// walk through the LANES chained digit cells in STEPS steps, and the merge loads the result.
// The output register frees the input side: the next beat is taken while a result waits.
// arst_n clears the sequencer and the output valid; data registers are not reset.
// A stalled output holds the sequencer in its merge state until the register drains.
module signed_bcd_adder
	import sbcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // a_negative, a_digits, b_negative, b_digits
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // sum_negative, sum_digits, carry_digit, digit_count
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_MERGE = 3'b100
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	pad_t              big_q;
	pad_t              small_q;
	pad_t              res_q;
	logic              sub_q;
	logic              neg_q;
	logic              cy_q;
	logic              cy_fin_q;
	result_t           out_q;
	logic              out_valid_q;

	pad_t              a_mag;
	pad_t              b_mag;
	logic              a_neg;
	logic              b_neg;
	logic              s_fire;
	logic              out_free;
	logic              last_step;
	logic [LANES:0]    chain;
	logic [LANE_DW-1:0] lane_d;
	result_t           merged;

	// unpack the beat, dropping nibbles above DIGITS
	always_comb begin
		a_neg = s_tdata[0];
		a_mag = pad_t'(s_tdata[DIG_W:1]);
		b_neg = s_tdata[65];
		b_mag = pad_t'(s_tdata[66 + DIG_W - 1:66]);
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign last_step = (step_q == STEP_W'(LAST_STEP));

	// digit lanes, carry chained from lane 0 upward
	assign chain[0] = cy_q;
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		sbcd_digit_cell u_cell (
			.sub  (sub_q),
			.x    (big_q[4*l +: 4]),
			.y    (small_q[4*l +: 4]),
			.cin  (chain[l]),
			.d    (lane_d[4*l +: 4]),
			.cout (chain[l+1])
		);
	end

	sbcd_merge u_merge (
		.digits   (res_q[DIG_W-1:0]),
		.carry    (cy_fin_q),
		.negative (neg_q),
		.result   (merged)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output valid: set when the merge loads the register, cleared when the beat leaves
			if ((state_q == ST_MERGE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (last_step) begin
						state_q <= ST_MERGE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_MERGE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operand setup, digit walk and output register
	always_ff @(posedge clk) begin
		if (s_fire) begin
			// plain nibble-string compare equals an unsigned compare
			sub_q <= a_neg ^ b_neg;
			cy_q  <= 1'b0;
			if ((a_neg == b_neg) || (a_mag >= b_mag)) begin
				big_q   <= a_mag;
				small_q <= b_mag;
				neg_q   <= a_neg;
			end else begin
				big_q   <= b_mag;
				small_q <= a_mag;
				neg_q   <= b_neg;
			end
		end else if (state_q == ST_RUN) begin
			big_q   <= big_q >> LANE_DW;
			small_q <= small_q >> LANE_DW;
			res_q   <= pad_t'({lane_d, res_q[PAD_W-1:LANE_DW]});
			cy_q    <= chain[LANES];
			if (last_step) begin
				cy_fin_q <= chain[LAST_LANE+1] && !sub_q;
			end
		end
		if ((state_q == ST_MERGE) && out_free) begin
			out_q <= merged;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.digit_count, out_q.carry_digit,
		out_q.sum_digits, out_q.sum_negative};

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for signed_bcd_adder: drives operand beats with random gaps and
// output stalls, predicts each signed BCD sum in-bench and compares every result beat.
// Depends on sbcd_pkg and the signed_bcd_adder RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sbcd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [FIELD_W-1:0] ALL_NINES = {DIGITS{4'h9}};
	localparam logic [FIELD_W-1:0] ALL_F     = {FIELD_W{1'b1}};

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;   // a_negative, a_digits, b_negative, b_digits
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // sum_negative, sum_digits, carry_digit, digit_count

	result_t expected_sums[$];
	result_t got_sum;
	result_t want_sum;
	int      fault_count  = 0;
	int      quiet_cycles = 0;
	int      snd_idle_pct = 0;
	int      rcv_idle_pct = 0;
	int      hold_left    = 0;

	signed_bcd_adder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected sign, digits, carry and digit count of one sum
	function automatic result_t predict_sum(input logic a_neg, input logic [FIELD_W-1:0] a_mag,
			input logic b_neg, input logic [FIELD_W-1:0] b_mag);
		result_t r;
		logic [FIELD_W-1:0] big;
		logic [FIELD_W-1:0] little;
		logic [4:0] s;
		int d;
		int order;
		logic carry;
		logic borrow;
		r = '0;
		carry = 1'b0;
		borrow = 1'b0;
		order = 0;
		if (a_neg == b_neg) begin
			// same signs: decimal add, common sign
			for (int i = 0; i < DIGITS; i++) begin
				s = 5'(a_mag[4*i +: 4]) + 5'(b_mag[4*i +: 4]) + 5'(carry);
				if (s >= 5'd10) begin
					r.sum_digits[4*i +: 4] = 4'(s - 5'd10);
					carry = 1'b1;
				end else begin
					r.sum_digits[4*i +: 4] = s[3:0];
					carry = 1'b0;
				end
			end
			r.sum_negative = a_neg;
			r.carry_digit = carry;
		end else begin
			// opposite signs: nibble-string compare from the top, then larger minus smaller
			for (int i = DIGITS - 1; i >= 0; i--) begin
				if (order == 0) begin
					if (a_mag[4*i +: 4] > b_mag[4*i +: 4])
						order = 1;
					else if (a_mag[4*i +: 4] < b_mag[4*i +: 4])
						order = -1;
				end
			end
			if (order >= 0) begin
				big = a_mag;
				little = b_mag;
				r.sum_negative = a_neg;
			end else begin
				big = b_mag;
				little = a_mag;
				r.sum_negative = b_neg;
			end
			for (int i = 0; i < DIGITS; i++) begin
				d = int'(big[4*i +: 4]) - int'(little[4*i +: 4]) - int'(borrow);
				if (d < 0) begin
					r.sum_digits[4*i +: 4] = 4'(d + 10);
					borrow = 1'b1;
				end else begin
					r.sum_digits[4*i +: 4] = 4'(d);
					borrow = 1'b0;
				end
			end
			r.carry_digit = 1'b0;
		end
		// zero is always positive
		if (r.sum_digits == '0 && !r.carry_digit)
			r.sum_negative = 1'b0;
		r.digit_count = CNT_W'(1);
		if (r.carry_digit) begin
			r.digit_count = CNT_W'(DIGITS + 1);
		end else begin
			for (int i = 0; i < DIGITS; i++)
				if (r.sum_digits[4*i +: 4] != 4'h0)
					r.digit_count = CNT_W'(i + 1);
		end
		return r;
	endfunction

	function automatic string show_sum(input result_t r);
		return $sformatf("sign=%0b digits=%016h carry=%0b count=%0d",
			r.sum_negative, r.sum_digits, r.carry_digit, r.digit_count);
	endfunction

	function automatic logic [FIELD_W-1:0] rand_bcd(input int ndig);
		logic [FIELD_W-1:0] v;
		v = '0;
		for (int i = 0; i < ndig; i++)
			v[4*i +: 4] = 4'($urandom_range(9));
		return v;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("mismatch %0d at %0t: %s", fault_count, $realtime, msg);
	endtask

	// one operand beat, with a random gap in front; expectation queued on acceptance
	task automatic send_operands(input logic an, input logic [FIELD_W-1:0] ad,
			input logic bn, input logic [FIELD_W-1:0] bd);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - 2*FIELD_W - 2){1'b0}}, bd, bn, ad, an};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_sums.push_back(predict_sum(an, ad, bn, bd));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed BCD with structure, some raw nibble noise
	task automatic send_random_pair();
		logic [FIELD_W-1:0] ad;
		logic [FIELD_W-1:0] bd;
		logic [FIELD_W-1:0] tmp;
		int kind;
		int pos;
		kind = $urandom_range(99);
		ad = rand_bcd($urandom_range(1, DIGITS));
		bd = rand_bcd($urandom_range(1, DIGITS));
		if (kind < 15) begin
			// equal magnitudes
			bd = ad;
		end else if (kind < 30) begin
			// magnitudes differing in at most one digit
			pos = $urandom_range(DIGITS - 1);
			bd = ad;
			bd[4*pos +: 4] = 4'($urandom_range(9));
		end else if (kind < 42) begin
			// long carry or borrow ripple
			ad = ALL_NINES >> (4 * $urandom_range(DIGITS - 1));
			bd = rand_bcd($urandom_range(1, 3));
			if ($urandom_range(1)) begin
				tmp = (ad + 1'b1) & ALL_NINES;
				ad = (tmp == '0) ? ad : ad + 1'b1;
			end
		end else if (kind < 54) begin
			ad = {$urandom, $urandom};
			bd = {$urandom, $urandom};
		end
		if ($urandom_range(1)) begin
			tmp = ad;
			ad = bd;
			bd = tmp;
		end
		send_operands(1'($urandom_range(1)), ad, 1'($urandom_range(1)), bd);
	endtask

	// extremes, zero-sign rules, carry out, borrow chains and non-decimal nibbles
	task automatic test_corner_cases();
		snd_idle_pct = 10;
		rcv_idle_pct = 69;
		send_operands(1'b0, '0, 1'b0, '0);
		send_operands(1'b1, '0, 1'b1, '0);
		send_operands(1'b0, '0, 1'b1, '0);
		send_operands(1'b1, '0, 1'b0, '0);
		send_operands(1'b0, ALL_NINES, 1'b0, ALL_NINES);
		send_operands(1'b1, ALL_NINES, 1'b1, 64'h1);
		send_operands(1'b0, 64'h1234, 1'b1, 64'h1234);
		send_operands(1'b1, 64'h1234, 1'b0, 64'h1234);
		send_operands(1'b0, 64'h1000_0000_0000_0000, 1'b1, 64'h1);
		send_operands(1'b1, 64'h1, 1'b0, 64'h1000_0000_0000_0000);
		send_operands(1'b0, 64'h5, 1'b1, 64'h7);
		send_operands(1'b1, 64'h5, 1'b0, 64'h7);
		send_operands(1'b0, ALL_F, 1'b0, ALL_F);
		send_operands(1'b0, ALL_F, 1'b1, '0);
		send_operands(1'b0, 64'hA, 1'b1, 64'hB);
		send_operands(1'b0, '0, 1'b1, ALL_F);
		send_operands(1'b0, 64'h9, 1'b0, 64'h1);
		send_operands(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h5555_5555_5555_5555);
		send_operands(1'b0, 64'h8000_0000_0000_0000, 1'b1, 64'h7999_9999_9999_9999);
		send_operands(1'b0, 64'h1, 1'b1, ALL_NINES);
		send_operands(1'b0, 64'h5555_5555_5555_5555, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_operands(1'b1, ALL_F, 1'b0, ALL_F);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		repeat (count)
			send_random_pair();
		wait_drained();
	endtask

	// output held off for a long stretch while operands keep coming
	task automatic test_output_hold();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (40)
			send_random_pair();
		wait_drained();
	endtask

	// sender stops mid-stream until all results are back, then resumes
	task automatic test_drain_pause();
		snd_idle_pct = 0;
		rcv_idle_pct = 30;
		repeat (30)
			send_random_pair();
		wait_drained();
		repeat (30)
			send_random_pair();
		wait_drained();
	endtask

	// output side: random stalls, or a counted hold-off when requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// result checker: each beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_sum = m_tdata[$bits(result_t)-1:0];
			if (expected_sums.size() == 0) begin
				note_fault({"result beat with nothing pending: ", show_sum(got_sum)});
			end else begin
				want_sum = expected_sums.pop_front();
				if (got_sum.sum_negative !== want_sum.sum_negative
						|| got_sum.sum_digits !== want_sum.sum_digits
						|| got_sum.carry_digit !== want_sum.carry_digit
						|| got_sum.digit_count !== want_sum.digit_count)
					note_fault({"expected ", show_sum(want_sum), " got ", show_sum(got_sum)});
			end
		end
	end

	// watchdog: too long without any beat on either side
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// test sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_random_traffic(540, 10, 69);
		test_random_traffic(540, 69, 10);
		test_random_traffic(540, 0, 0);
		test_output_hold();
		test_drain_pause();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0)
			note_fault($sformatf("%0d results never arrived", expected_sums.size()));
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
src/sbcd_pkg.sv
src/sbcd_digit_cell.sv
src/sbcd_merge.sv
src/signed_bcd_adder.sv
tb/tb_top.sv
